// ===== sv/tsf_pkg.sv =====
// Shared constants and types for the trapezoidal shaping filter.
package tsf_pkg;

    localparam int MAX_PEAK      = 1024;
    localparam int MAX_GAP       = 1024;
    localparam int HISTORY_DEPTH = 4096;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);

    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W    = 26;
    localparam int OUT_W    = 27;
    localparam int SEEN_W   = $clog2(2 * MAX_PEAK + MAX_GAP + 2);

    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIME  = 2'd1;

    localparam logic [CFG_W-1:0] PEAK_RESET = CFG_W'(510);
    localparam logic [CFG_W-1:0] GAP_RESET  = CFG_W'(510);

    typedef logic [HIST_AW-1:0]  hist_addr_t;
    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [SUM_W-1:0]    sum_t;

    typedef struct packed {
        sample_t sample;
        logic    first;
        logic    use_lead;
        logic    add_lag;
        logic    sub_lag;
        logic    emit;
    } tap_req_t;

    typedef struct packed {
        hist_addr_t lead;
        hist_addr_t lag_add;
        hist_addr_t lag_sub;
    } tap_addr_t;

    typedef struct packed {
        sample_t lead;
        sample_t lag_add;
        sample_t lag_sub;
    } tap_data_t;

endpackage

// ===== sv/tsf_history.sv =====
// Sample history ring: two synchronous memories giving three registered read taps.
module tsf_history (
    input  logic                clk,
    input  logic                access,
    input  tsf_pkg::hist_addr_t wr_addr,
    input  tsf_pkg::sample_t    wr_data,
    input  tsf_pkg::tap_addr_t  rd_addr,
    output tsf_pkg::tap_data_t  rd_data
);

    tsf_pkg::sample_t mem_a [tsf_pkg::HISTORY_DEPTH];
    tsf_pkg::sample_t mem_b [tsf_pkg::HISTORY_DEPTH];

    tsf_pkg::tap_data_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (access)
        begin
            mem_a[wr_addr]      <= wr_data;
            mem_b[wr_addr]      <= wr_data;
            rd_data_reg.lead    <= mem_a[rd_addr.lead];
            rd_data_reg.lag_add <= mem_a[rd_addr.lag_add];
            rd_data_reg.lag_sub <= mem_b[rd_addr.lag_sub];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/tsf_sequencer.sv =====
// Configuration registers, write pointer, sample count and tap address generation.
module tsf_sequencer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tsf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tsf_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          accept,
    input  tsf_pkg::sample_t              sample,
    input  logic                          first_of_waveform,
    output tsf_pkg::hist_addr_t           wr_addr,
    output tsf_pkg::tap_addr_t            rd_addr,
    output tsf_pkg::tap_req_t             req
);

    localparam int SW = tsf_pkg::SEEN_W;

    logic [tsf_pkg::CFG_W-1:0] peak_time_reg;
    logic [tsf_pkg::CFG_W-1:0] gap_time_reg;
    tsf_pkg::hist_addr_t       wp_reg;
    logic [SW-1:0]             seen_reg;
    logic [SW-1:0]             seen_next;

    logic [SW-1:0] p_eff;
    logic [SW-1:0] g_eff;
    logic [SW-1:0] pg;
    logic [SW-1:0] full;
    logic [SW-1:0] limit;
    logic [SW-1:0] seen_base;
    logic [SW:0]   seen_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_time_reg <= tsf_pkg::PEAK_RESET;
            gap_time_reg  <= tsf_pkg::GAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tsf_pkg::CFG_PEAK_TIME: peak_time_reg <= cfg_data;
                tsf_pkg::CFG_GAP_TIME:  gap_time_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (peak_time_reg == '0)
            p_eff = SW'(1);
        else if (SW'(peak_time_reg) > SW'(tsf_pkg::MAX_PEAK))
            p_eff = SW'(tsf_pkg::MAX_PEAK);
        else
            p_eff = SW'(peak_time_reg);

        if (SW'(gap_time_reg) > SW'(tsf_pkg::MAX_GAP))
            g_eff = SW'(tsf_pkg::MAX_GAP);
        else
            g_eff = SW'(gap_time_reg);

        pg    = p_eff + g_eff;
        full  = pg + p_eff;
        limit = full + SW'(1);

        seen_base = first_of_waveform ? '0 : seen_reg;
        seen_inc  = {1'b0, seen_base} + (SW+1)'(1);
        if (seen_inc > {1'b0, limit})
            seen_next = limit;
        else
            seen_next = seen_inc[SW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            seen_reg <= '0;
        end
        else if (accept)
        begin
            wp_reg   <= wp_reg + tsf_pkg::HIST_AW'(1);
            seen_reg <= seen_next;
        end
    end

    assign wr_addr         = wp_reg;
    assign rd_addr.lead    = wp_reg - tsf_pkg::HIST_AW'(p_eff);
    assign rd_addr.lag_add = wp_reg - tsf_pkg::HIST_AW'(pg);
    assign rd_addr.lag_sub = wp_reg - tsf_pkg::HIST_AW'(full);

    assign req.sample   = sample;
    assign req.first    = first_of_waveform;
    assign req.use_lead = seen_next > p_eff;
    assign req.add_lag  = seen_next > pg;
    assign req.sub_lag  = seen_next > full;
    assign req.emit     = seen_next >= full;

endmodule

// ===== sv/tsf_accum.sv =====
// Running-sum update from the history taps and the result output register.
module tsf_accum (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  tsf_pkg::tap_req_t   req,
    input  tsf_pkg::tap_data_t  taps,
    output logic                busy,
    output logic                out_valid,
    input  logic                out_stall,
    output tsf_pkg::sum_t       out_lead,
    output tsf_pkg::sum_t       out_lag
);

    localparam int SUM_W = tsf_pkg::SUM_W;

    logic              s1_valid_reg;
    tsf_pkg::tap_req_t s1_req_reg;
    tsf_pkg::sum_t     lead_reg;
    tsf_pkg::sum_t     lag_reg;
    tsf_pkg::sum_t     lead_next;
    tsf_pkg::sum_t     lag_next;
    logic              out_valid_reg;
    tsf_pkg::sum_t     out_lead_reg;
    tsf_pkg::sum_t     out_lag_reg;

    logic out_free;
    logic s1_go;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_go    = s1_valid_reg && (!s1_req_reg.emit || out_free);
    assign busy     = s1_valid_reg && !s1_go;

    always_comb
    begin
        tsf_pkg::sum_t lead_base;
        tsf_pkg::sum_t lag_base;
        lead_base = s1_req_reg.first ? '0 : lead_reg;
        lag_base  = s1_req_reg.first ? '0 : lag_reg;
        lead_next = lead_base + SUM_W'(s1_req_reg.sample)
                  - (s1_req_reg.use_lead ? SUM_W'(taps.lead) : '0);
        lag_next  = lag_base
                  + (s1_req_reg.add_lag ? SUM_W'(taps.lag_add) : '0)
                  - (s1_req_reg.sub_lag ? SUM_W'(taps.lag_sub) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            lead_reg      <= '0;
            lag_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_go)
                s1_valid_reg <= 1'b0;

            if (s1_go)
            begin
                lead_reg <= lead_next;
                lag_reg  <= lag_next;
            end

            if (s1_go && s1_req_reg.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_req_reg <= req;
        if (s1_go && s1_req_reg.emit)
        begin
            out_lead_reg <= lead_next;
            out_lag_reg  <= lag_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_lead  = out_lead_reg;
    assign out_lag   = out_lag_reg;

endmodule

// ===== sv/trapezoidal_shaping_filter.sv =====
// Top level of the trapezoidal shaping filter.
//
// Input channel: in_valid/in_stall carry one request of sample and
// first_of_waveform. Output channel: out_valid/out_stall carry shaped_value,
// the leading window sum minus the lagging window sum, two's complement.
// Configuration: cfg_we writes cfg_data into the register at cfg_index
// (0 peak_time, 1 gap_time); other indexes are ignored.
// Throughput: one sample per cycle while in_stall is low. Each request
// reads three history taps from the sample ring in the cycle it is accepted;
// the running sums are then updated from the registered tap data.
// A result passes from the tap stage into the output register to show on out_valid.
// A waveform gives its first result on sample 2*peak_time+gap_time (zero peak as 1,
// both capped at 1024) and one per sample from then on; earlier samples give none.
// Reset clears the sums, sample count and write pointer and loads 510 into
// both registers; the ring itself is not cleared.
// When the receiver stalls, the result is held in the output register and
// one further sample may be taken into the tap stage; in_stall rises only
// once that stage holds a request that has a result to deliver.
module trapezoidal_shaping_filter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tsf_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [tsf_pkg::SAMPLE_W-1:0]       sample,
    input  logic                               first_of_waveform,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [tsf_pkg::OUT_W-1:0]   shaped_value
);

    logic                accept;
    logic                busy;
    tsf_pkg::hist_addr_t wr_addr;
    tsf_pkg::tap_addr_t  rd_addr;
    tsf_pkg::tap_data_t  taps;
    tsf_pkg::tap_req_t   req;
    tsf_pkg::sum_t       out_lead;
    tsf_pkg::sum_t       out_lag;

    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    tsf_sequencer u_sequencer (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .accept            (accept),
        .sample            (sample),
        .first_of_waveform (first_of_waveform),
        .wr_addr           (wr_addr),
        .rd_addr           (rd_addr),
        .req               (req)
    );

    tsf_history u_history (
        .clk     (clk),
        .access  (accept),
        .wr_addr (wr_addr),
        .wr_data (sample),
        .rd_addr (rd_addr),
        .rd_data (taps)
    );

    tsf_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req       (req),
        .taps      (taps),
        .busy      (busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_lead  (out_lead),
        .out_lag   (out_lag)
    );

    assign shaped_value = $signed({1'b0, out_lead} - {1'b0, out_lag});

endmodule

// ===== tb/sv/trapezoidal_shaping_filter_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the trapezoidal shaping filter: directed, extreme and random waveforms.
module trapezoidal_shaping_filter_tb;
    import tsf_pkg::*;

    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 300;
    localparam int CALM_ITEMS    = 80;
    localparam int CLAMP_ITEMS   = 32;
    localparam int WIDE_PEAK     = 64;
    localparam int LONG_HOLD     = 60;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 2000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    class shaper_scoreboard;
        bit [CFG_W-1:0]    peak_reg = PEAK_RESET;
        bit [CFG_W-1:0]    gap_reg  = GAP_RESET;
        bit [SAMPLE_W-1:0] ring [HISTORY_DEPTH];
        int unsigned       wr_ptr;
        int unsigned       seen;
        bit [SUM_W-1:0]    lead_sum;
        bit [SUM_W-1:0]    lag_sum;
        bit [OUT_W-1:0]    pending_shaped [$];
        int unsigned       mismatches;

        function int unsigned peak_len();
            if (peak_reg == 0)
                return 1;
            if (peak_reg > MAX_PEAK)
                return MAX_PEAK;
            return peak_reg;
        endfunction

        function int unsigned gap_len();
            return (gap_reg > MAX_GAP) ? MAX_GAP : gap_reg;
        endfunction

        function int unsigned full_delay();
            return 2 * peak_len() + gap_len();
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_PEAK_TIME)
                peak_reg = data;
            else if (idx == CFG_GAP_TIME)
                gap_reg = data;
        endfunction

        function bit [SAMPLE_W-1:0] ring_back(int unsigned back);
            return ring[(wr_ptr + HISTORY_DEPTH - back % HISTORY_DEPTH) % HISTORY_DEPTH];
        endfunction

        function void note_sample(bit [SAMPLE_W-1:0] x, bit first);
            int unsigned p;
            int unsigned g;
            int unsigned full;
            p    = peak_len();
            g    = gap_len();
            full = 2 * p + g;
            if (first)
            begin
                seen     = 0;
                lead_sum = '0;
                lag_sum  = '0;
            end
            wr_ptr       = wr_ptr % HISTORY_DEPTH;
            ring[wr_ptr] = x;
            seen         = (seen + 1 > full + 1) ? full + 1 : seen + 1;
            lead_sum     = lead_sum + x;
            if (seen > p)
                lead_sum = lead_sum - ring_back(p);
            if (seen > p + g)
                lag_sum = lag_sum + ring_back(p + g);
            if (seen > full)
                lag_sum = lag_sum - ring_back(full);
            wr_ptr = (wr_ptr + 1) % HISTORY_DEPTH;
            if (seen >= full)
                pending_shaped.push_back({1'b0, lead_sum} - {1'b0, lag_sum});
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] shaped_value mismatch: %s", $time, what);
        endtask

        task check_shaped(logic [OUT_W-1:0] got);
            bit [OUT_W-1:0] want;
            if (pending_shaped.size() == 0)
                report_mismatch($sformatf("result %0d with none outstanding", $signed(got)));
            else
            begin
                want = pending_shaped.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("got %0d, expected %0d",
                                              $signed(got), $signed(want)));
            end
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [SAMPLE_W-1:0]  sample;
    logic                 first_of_waveform;
    logic                 out_valid;
    logic                 out_stall;
    logic signed [OUT_W-1:0] shaped_value;

    shaper_scoreboard board = new;
    bit          in_idling    = 1'b1;
    bit          out_idling   = 1'b1;
    bit          hold_request = 1'b0;
    bit          hold_due     = 1'b0;
    int unsigned sent         = 0;
    int          quiet_cycles = 0;

    trapezoidal_shaping_filter i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .sample            (sample),
        .first_of_waveform (first_of_waveform),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .shaped_value      (shaped_value)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            board.note_sample(sample, first_of_waveform);
        if (rst_n && out_valid === 1'b1 && !out_stall)
            board.check_shaped(shaped_value);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (out_idling && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic first);
        @(negedge clk);
        if (in_idling && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid          <= 1'b1;
        sample            <= x;
        first_of_waveform <= first;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending_shaped.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.write_register(idx, data);
    endtask

    task automatic send_waveform(input int unsigned len, input bit fresh);
        int unsigned         style;
        int unsigned         step_at;
        int unsigned         full;
        logic [SAMPLE_W-1:0] base;
        logic [SAMPLE_W-1:0] height;
        logic [SAMPLE_W-1:0] x;
        style   = $urandom_range(0, 3);
        full    = board.full_delay();
        base    = SAMPLE_W'($urandom_range(0, 4000));
        height  = SAMPLE_W'($urandom_range(0, 60000));
        step_at = $urandom_range(0, len);
        for (int unsigned i = 0; i < len; i++)
        begin
            case (style)
                0:       x = SAMPLE_W'($urandom);
                1:       x = (i < step_at) ? base : base + height;
                2:       x = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
                default: x = SAMPLE_W'(base + $urandom_range(0, 255)
                                       + ((i >= step_at) ? height : 16'h0));
            endcase
            if (hold_due && fresh && i + 1 >= full && len - i > 8)
            begin
                hold_due     = 1'b0;
                hold_request = 1'b1;
            end
            send_sample(x, fresh && i == 0);
        end
    endtask

    initial
    begin
        int unsigned random_start;
        int unsigned hold_mark;
        int unsigned full;
        int unsigned len;
        int unsigned peak;
        int unsigned gap;
        int unsigned r;
        bit          carry_on;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_PEAK_TIME;
        cfg_data          = '0;
        in_valid          = 1'b0;
        sample            = '0;
        first_of_waveform = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // shortest windows: output is the plain first difference
        program_register(CFG_PEAK_TIME, CFG_W'(1));
        program_register(CFG_GAP_TIME, CFG_W'(0));
        send_sample(16'h0000, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'h1234, 1'b1);
        send_sample(16'h8001, 1'b0);
        drain();

        // zero peak clamps to one; spare index is ignored
        program_register(CFG_PEAK_TIME, CFG_W'(0));
        program_register(CFG_GAP_TIME, CFG_W'(3));
        program_register(CFG_SPARE, '1);
        send_sample(16'h0007, 1'b1);
        send_sample(16'h0100, 1'b0);
        send_sample(16'h0000, 1'b1);
        for (int i = 0; i < 7; i++)
            send_sample(16'(i * 9000), 1'b0);
        drain();

        // oversized windows clamp to the widest: too short to give a result
        program_register(CFG_PEAK_TIME, '1);
        program_register(CFG_GAP_TIME, '1);
        for (int i = 0; i < CLAMP_ITEMS; i++)
            send_sample(16'(i * 2000), i == 0);
        drain();

        // wide windows, driven to both extremes for that window length
        program_register(CFG_PEAK_TIME, CFG_W'(WIDE_PEAK));
        program_register(CFG_GAP_TIME, CFG_W'(WIDE_PEAK));
        for (int i = 0; i < 4 * WIDE_PEAK + 4; i++)
            send_sample((i >= WIDE_PEAK && i < 3 * WIDE_PEAK) ? 16'hFFFF : 16'h0000, i == 0);
        drain();
        program_register(CFG_PEAK_TIME, CFG_W'(4));
        program_register(CFG_GAP_TIME, CFG_W'(2));

        random_start = sent;
        hold_mark    = 40;
        carry_on     = 1'b0;
        while (sent - random_start < RANDOM_ITEMS)
        begin
            if (RANDOM_ITEMS - (sent - random_start) <= CALM_ITEMS)
            begin
                in_idling  = 1'b0;
                out_idling = 1'b0;
            end
            else
            begin
                in_idling  = $urandom_range(0, 3) != 0;
                out_idling = $urandom_range(0, 3) != 0;
            end
            if ($urandom_range(0, 2) == 0)
            begin
                drain();
                r    = $urandom_range(0, 9);
                peak = (r == 0) ? 0 : (r <= 6) ? $urandom_range(1, 6) : $urandom_range(7, 24);
                r    = $urandom_range(0, 9);
                gap  = (r <= 2) ? 0 : (r <= 7) ? $urandom_range(1, 6) : $urandom_range(7, 20);
                if ($urandom_range(0, 4) != 0)
                    program_register(CFG_PEAK_TIME, CFG_W'(peak));
                program_register(CFG_GAP_TIME, CFG_W'(gap));
                if ($urandom_range(0, 9) == 0)
                    program_register(CFG_SPARE, CFG_W'($urandom));
                carry_on = $urandom_range(0, 3) == 0;
            end
            else if ($urandom_range(0, 9) == 0)
                drain();
            if (sent - random_start >= hold_mark)
            begin
                hold_due  = 1'b1;
                hold_mark = hold_mark + 150;
            end
            full = board.full_delay();
            if ($urandom_range(0, 6) == 0)
                len = $urandom_range(1, full - 1);
            else
                len = full + $urandom_range(0, 40);
            send_waveform(len, !carry_on && $urandom_range(0, 9) != 0);
            carry_on = 1'b0;
        end

        drain();
        if (board.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
